// File: hdl/srb_pkg.sv
// Package: widths, opcodes, controller states and command/status structs for the sorted buffer.
`default_nettype none
package srb_pkg;

  localparam int OpW = 2;
  localparam int KeyW = 14;
  localparam int IdW = 32;
  localparam int CntW = 5;
  localparam int DEFAULT_DEPTH = 16;

  typedef enum logic [OpW-1:0] {
    OP_INS_SORTED = 2'd0,
    OP_INS_FRONT  = 2'd1,
    OP_REM_FIRST  = 2'd2,
    OP_REM_LAST   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_INSERT,
    ST_POP_FIRST,
    ST_LAST_RD,
    ST_POP_LAST,
    ST_FAIL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic cur_load;
    logic cur_dec;
    logic rd;
    logic ins;
    logic pop_first;
    logic pop_last;
    logic fail;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic key_gt;
    logic cur_one;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/srb_in_if.sv
// Interface: request channel carrying one buffer operation.
`default_nettype none
interface srb_in_if;
  logic                     valid;
  logic                     ready;
  logic [srb_pkg::OpW-1:0]  opcode;
  logic [srb_pkg::KeyW-1:0] key;
  logic [srb_pkg::IdW-1:0]  ident;

  modport source (output valid, output opcode, output key, output ident, input ready);
  modport sink (input valid, input opcode, input key, input ident, output ready);
endinterface
`default_nettype wire

// File: hdl/srb_out_if.sv
// Interface: response channel carrying one operation result.
`default_nettype none
interface srb_out_if;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic [srb_pkg::KeyW-1:0] out_key;
  logic [srb_pkg::IdW-1:0]  out_ident;
  logic [srb_pkg::CntW-1:0] count;
  logic                     empty_res;

  modport source (output valid, output ok, output out_key, output out_ident, output count,
                  output empty_res, input ready);
  modport sink (input valid, input ok, input out_key, input out_ident, input count,
                input empty_res, output ready);
endinterface
`default_nettype wire

// File: hdl/srb_ctrl.sv
// Controller: sequences decode, insert-position scan, shifts and result handoff.
`default_nettype none
module srb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire srb_pkg::status_t sts,
  output srb_pkg::cmd_t         cmd
);

  srb_pkg::state_t state;
  srb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      srb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = srb_pkg::ST_DECODE;
        end
      end
      srb_pkg::ST_DECODE: begin
        cmd.cur_load = 1'b1;
        priority if ((sts.op == srb_pkg::OP_INS_SORTED || sts.op == srb_pkg::OP_INS_FRONT)
                     && sts.full) begin
          state_next = srb_pkg::ST_FAIL;
        end else if ((sts.op == srb_pkg::OP_REM_FIRST || sts.op == srb_pkg::OP_REM_LAST)
                     && sts.empty) begin
          state_next = srb_pkg::ST_FAIL;
        end else if (sts.op == srb_pkg::OP_INS_SORTED && !sts.empty) begin
          state_next = srb_pkg::ST_SCAN_RD;
        end else if (sts.op == srb_pkg::OP_REM_FIRST) begin
          state_next = srb_pkg::ST_POP_FIRST;
        end else if (sts.op == srb_pkg::OP_REM_LAST) begin
          state_next = srb_pkg::ST_LAST_RD;
        end else begin
          state_next = srb_pkg::ST_INSERT;
        end
      end
      srb_pkg::ST_SCAN_RD: begin
        cmd.rd = 1'b1;
        state_next = srb_pkg::ST_SCAN_CMP;
      end
      srb_pkg::ST_SCAN_CMP: begin
        if (sts.key_gt) begin
          cmd.cur_dec = 1'b1;
          state_next = sts.cur_one ? srb_pkg::ST_INSERT : srb_pkg::ST_SCAN_RD;
        end else begin
          state_next = srb_pkg::ST_INSERT;
        end
      end
      srb_pkg::ST_INSERT: begin
        cmd.ins = 1'b1;
        state_next = srb_pkg::ST_RESULT;
      end
      srb_pkg::ST_POP_FIRST: begin
        cmd.pop_first = 1'b1;
        state_next = srb_pkg::ST_RESULT;
      end
      srb_pkg::ST_LAST_RD: begin
        cmd.rd = 1'b1;
        state_next = srb_pkg::ST_POP_LAST;
      end
      srb_pkg::ST_POP_LAST: begin
        cmd.pop_last = 1'b1;
        state_next = srb_pkg::ST_RESULT;
      end
      srb_pkg::ST_FAIL: begin
        cmd.fail = 1'b1;
        state_next = srb_pkg::ST_RESULT;
      end
      srb_pkg::ST_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = srb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/srb_datapath.sv
// Datapath: record cells with parallel shift, cursor, read register and result registers.
`default_nettype none
module srb_datapath #(
  parameter int BUFFER_DEPTH = srb_pkg::DEFAULT_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire srb_pkg::cmd_t            cmd,
  output srb_pkg::status_t              sts,
  input  wire logic [srb_pkg::OpW-1:0]  in_opcode,
  input  wire logic [srb_pkg::KeyW-1:0] in_key,
  input  wire logic [srb_pkg::IdW-1:0]  in_ident,
  output logic                          res_ok,
  output logic [srb_pkg::KeyW-1:0]      res_key,
  output logic [srb_pkg::IdW-1:0]       res_ident,
  output logic [srb_pkg::CntW-1:0]      res_count,
  output logic                          res_empty
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int IW = $clog2(BUFFER_DEPTH);

  logic [srb_pkg::KeyW-1:0] keys [BUFFER_DEPTH];
  logic [srb_pkg::IdW-1:0]  idents [BUFFER_DEPTH];

  srb_pkg::op_t             item_op;
  logic [srb_pkg::KeyW-1:0] item_key;
  logic [srb_pkg::IdW-1:0]  item_ident;
  logic [CW-1:0]            fill;
  logic [CW-1:0]            cursor;
  logic [CW-1:0]            rd_idx;
  logic [srb_pkg::KeyW-1:0] rd_key;
  logic [srb_pkg::IdW-1:0]  rd_ident;

  assign rd_idx = cursor - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op <= srb_pkg::op_t'(in_opcode);
      item_key <= in_key;
      item_ident <= in_ident;
    end
    if (cmd.rd) begin
      rd_key <= keys[rd_idx[IW-1:0]];
      rd_ident <= idents[rd_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      cursor <= '0;
    end else begin
      if (cmd.cur_load) begin
        cursor <= (item_op == srb_pkg::OP_INS_FRONT) ? '0 : fill;
      end else if (cmd.cur_dec) begin
        cursor <= cursor - CW'(1);
      end
      if (cmd.ins) begin
        fill <= fill + CW'(1);
      end else if (cmd.pop_first || cmd.pop_last) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < BUFFER_DEPTH; j++) begin
      if (cmd.ins) begin
        if (cursor == CW'(j)) begin
          keys[j] <= item_key;
          idents[j] <= item_ident;
        end else if (j > 0 && cursor < CW'(j)) begin
          keys[j] <= keys[(j > 0) ? j - 1 : 0];
          idents[j] <= idents[(j > 0) ? j - 1 : 0];
        end
      end else if (cmd.pop_first && j < BUFFER_DEPTH - 1) begin
        keys[j] <= keys[(j < BUFFER_DEPTH - 1) ? j + 1 : j];
        idents[j] <= idents[(j < BUFFER_DEPTH - 1) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.pop_first) begin
      res_ok <= 1'b1;
      res_key <= keys[0];
      res_ident <= idents[0];
    end else if (cmd.pop_last) begin
      res_ok <= 1'b1;
      res_key <= rd_key;
      res_ident <= rd_ident;
    end else if (cmd.ins || cmd.fail) begin
      res_ok <= cmd.ins;
      res_key <= '0;
      res_ident <= '0;
    end
  end

  assign res_count = srb_pkg::CntW'(fill);
  assign res_empty = (fill == '0);

  assign sts.op = item_op;
  assign sts.full = (fill == CW'(BUFFER_DEPTH));
  assign sts.empty = (fill == '0);
  assign sts.key_gt = (rd_key > item_key);
  assign sts.cur_one = (cursor == CW'(1));

endmodule
`default_nettype wire

// File: hdl/sorted_record_buffer.sv
// Top level: sorted record buffer with request and response channels.
//
//   channel  modport  payload                                     transaction
//   req      sink     opcode, key, ident                          valid && ready
//   rsp      source   ok, out_key, out_ident, count, empty_res    valid && ready
//
// One transaction at a time. Insert at front, remove first, rejections and sorted insert
// into an empty buffer go through decode and the insert, pop or fail state; remove last
// adds a read before its pop. Sorted insert into a non-empty buffer reads and compares
// entries downward to the first not above the new key or slot 0; idle follows each result.
// Reset (rst, synchronous) empties the buffer; stored records need no clearing.
// A stalled response holds; no request is taken until it is delivered.
`default_nettype none
module sorted_record_buffer #(
  parameter int BUFFER_DEPTH = srb_pkg::DEFAULT_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  srb_in_if.sink   req,
  srb_out_if.source rsp
);

  srb_pkg::cmd_t    cmd;
  srb_pkg::status_t sts;

  srb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srb_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_opcode (req.opcode),
    .in_key    (req.key),
    .in_ident  (req.ident),
    .res_ok    (rsp.ok),
    .res_key   (rsp.out_key),
    .res_ident (rsp.out_ident),
    .res_count (rsp.count),
    .res_empty (rsp.empty_res)
  );

endmodule
`default_nettype wire

// File: sim/sorted_record_buffer_tb.sv
// Testbench: checks the sorted record buffer against its own predictor under random flow control.
module sorted_record_buffer_tb;

  localparam int KeyW = srb_pkg::KeyW;
  localparam int IdW = srb_pkg::IdW;
  localparam int CntW = srb_pkg::CntW;
  localparam int Depth = srb_pkg::DEFAULT_DEPTH;
  localparam int IdlePct = 31;
  localparam int SettleCycles = 4 + 2 * Depth + 8;
  localparam logic [KeyW-1:0] KeyTop = 14'd10000;
  localparam logic [KeyW-1:0] KeyMax = 14'd16383;

  typedef struct packed {
    logic            ok;
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  ident;
    logic [CntW-1:0] count;
    logic            empty;
  } buffer_result_t;

  logic clk = 1'b0;
  logic rst;

  srb_in_if  req_ch();
  srb_out_if rsp_ch();

  sorted_record_buffer #(.BUFFER_DEPTH(Depth)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [KeyW-1:0] model_keys [Depth];
  logic [IdW-1:0]  model_idents [Depth];
  int              model_fill;
  buffer_result_t  pending_results [$];
  int              error_count;
  bit              send_idle_on;
  bit              recv_stall_on;
  int              hold_request;
  int              hold_left;

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch %s: expected %0h, got %0h", what, want, got);
    error_count++;
  endtask

  task automatic apply_buffer_op(input srb_pkg::op_t op, input logic [KeyW-1:0] key,
                                 input logic [IdW-1:0] ident);
    buffer_result_t res;
    int pos;
    int j;
    res = '0;
    if (op == srb_pkg::OP_INS_SORTED || op == srb_pkg::OP_INS_FRONT) begin
      if (model_fill < Depth) begin
        pos = 0;
        if (op == srb_pkg::OP_INS_SORTED) begin
          pos = model_fill;
          while (pos > 0 && model_keys[pos-1] > key) pos--;
        end
        for (j = model_fill; j > pos; j--) begin
          model_keys[j] = model_keys[j-1];
          model_idents[j] = model_idents[j-1];
        end
        model_keys[pos] = key;
        model_idents[pos] = ident;
        model_fill++;
        res.ok = 1'b1;
      end
    end else if (model_fill > 0) begin
      if (op == srb_pkg::OP_REM_FIRST) begin
        res.key = model_keys[0];
        res.ident = model_idents[0];
        for (j = 0; j + 1 < model_fill; j++) begin
          model_keys[j] = model_keys[j+1];
          model_idents[j] = model_idents[j+1];
        end
      end else begin
        res.key = model_keys[model_fill-1];
        res.ident = model_idents[model_fill-1];
      end
      model_fill--;
      res.ok = 1'b1;
    end
    res.count = model_fill[CntW-1:0];
    res.empty = (model_fill == 0);
    pending_results.push_back(res);
  endtask

  task automatic send_op(input srb_pkg::op_t op, input logic [KeyW-1:0] key,
                         input logic [IdW-1:0] ident);
    bit accepted;
    while (send_idle_on && $urandom_range(0, 99) < IdlePct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key <= key;
    req_ch.ident <= ident;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = (req_ch.ready === 1'b1);
      @(posedge clk);
    end
    apply_buffer_op(op, key, ident);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 9))
      6, 7:    return KeyW'($urandom_range(0, 7));
      8:       return KeyW'($urandom_range(KeyTop + 1, KeyMax));
      9:       return ($urandom_range(0, 1) != 0) ? KeyMax : '0;
      default: return KeyW'($urandom_range(0, KeyTop));
    endcase
  endfunction

  task automatic test_empty_removes();
    send_op(srb_pkg::OP_REM_FIRST, KeyMax, '1);
    send_op(srb_pkg::OP_REM_LAST, KeyMax, '1);
  endtask

  task automatic test_sorted_extremes();
    send_op(srb_pkg::OP_INS_SORTED, 14'd5000, 32'h0000_1388);
    send_op(srb_pkg::OP_INS_SORTED, '0, '0);
    send_op(srb_pkg::OP_INS_SORTED, KeyMax, '1);
    send_op(srb_pkg::OP_INS_SORTED, KeyTop, 32'h0000_0001);
    send_op(srb_pkg::OP_INS_SORTED, KeyTop, 32'h0000_0002);
    send_op(srb_pkg::OP_INS_FRONT, '0, 32'h5555_5555);
    send_op(srb_pkg::OP_REM_FIRST, '0, '0);
    send_op(srb_pkg::OP_REM_LAST, '0, '0);
  endtask

  task automatic test_fill_and_reject();
    while (model_fill < Depth) send_op(srb_pkg::OP_INS_SORTED, pick_key(), $urandom);
    send_op(srb_pkg::OP_INS_SORTED, 14'd1, 32'hAAAA_AAAA);
    send_op(srb_pkg::OP_INS_FRONT, '0, 32'hAAAA_AAAA);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int num_items);
    int insert_pct;
    int i;
    srb_pkg::op_t op;
    logic [KeyW-1:0] key;
    insert_pct = 50;
    for (i = 0; i < num_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 75;
          1:       insert_pct = 25;
          default: insert_pct = 50;
        endcase
      end
      key = pick_key();
      if ($urandom_range(0, 99) < insert_pct) begin
        if ($urandom_range(0, 99) < 80) begin
          op = srb_pkg::OP_INS_SORTED;
        end else begin
          op = srb_pkg::OP_INS_FRONT;
          if ($urandom_range(0, 9) < 7)
            key = KeyW'($urandom_range(0, (model_fill > 0) ? model_keys[0] : KeyTop));
        end
      end else begin
        op = ($urandom_range(0, 1) != 0) ? srb_pkg::OP_REM_FIRST : srb_pkg::OP_REM_LAST;
        if ($urandom_range(0, 9) == 0) key = KeyMax;
      end
      send_op(op, key, $urandom);
    end
  endtask

  task automatic test_unthrottled(input int num_items);
    send_idle_on = 1'b0;
    recv_stall_on = 1'b0;
    test_random_traffic(num_items);
    wait_drained();
    send_idle_on = 1'b1;
    recv_stall_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_request = 300;
    test_random_traffic(30);
    wait_drained();
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_stall_on) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= IdlePct);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    buffer_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, count", '0, rsp_ch.count);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.ok !== want.ok) report_mismatch("ok", want.ok, rsp_ch.ok);
        if (rsp_ch.out_key !== want.key) report_mismatch("out_key", want.key, rsp_ch.out_key);
        if (rsp_ch.out_ident !== want.ident)
          report_mismatch("out_ident", want.ident, rsp_ch.out_ident);
        if (rsp_ch.count !== want.count) report_mismatch("count", want.count, rsp_ch.count);
        if (rsp_ch.empty_res !== want.empty)
          report_mismatch("empty_res", want.empty, rsp_ch.empty_res);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int j;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= srb_pkg::OP_INS_SORTED;
    req_ch.key <= '0;
    req_ch.ident <= '0;
    error_count = 0;
    send_idle_on = 1'b1;
    recv_stall_on = 1'b1;
    hold_request = 0;
    model_fill = 0;
    for (j = 0; j < Depth; j++) begin
      model_keys[j] = '0;
      model_idents[j] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_removes();
    test_sorted_extremes();
    test_fill_and_reject();
    test_random_traffic(450);
    wait_drained();
    test_backpressure();
    test_unthrottled(150);
    test_random_traffic(420);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/srb_pkg.sv
hdl/srb_in_if.sv
hdl/srb_out_if.sv
hdl/srb_ctrl.sv
hdl/srb_datapath.sv
hdl/sorted_record_buffer.sv
sim/sorted_record_buffer_tb.sv
